// ----- rtl/core/dq_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_pkg
// Shared types, constants and ring index helpers for the double-ended queue.
// ----------------------------------------------------------------------------
package dq_pkg;

	localparam int DEPTH  = 16;
	localparam int IDX_W  = $clog2(DEPTH);
	localparam int CNT_W  = $clog2(DEPTH + 1);
	localparam int WORD_W = 32;
	localparam int OCC_W  = 5;

	typedef logic [IDX_W-1:0]  idx_t;
	typedef logic [CNT_W-1:0]  cnt_t;
	typedef logic [WORD_W-1:0] word_t;

	typedef enum logic [1:0] {
		OP_PUSH_REAR  = 2'd0,
		OP_PUSH_FRONT = 2'd1,
		OP_POP_FRONT  = 2'd2,
		OP_POP_REAR   = 2'd3
	} op_t;

	typedef enum logic [1:0] {
		ST_DONE  = 2'd0,
		ST_FULL  = 2'd1,
		ST_EMPTY = 2'd2
	} status_t;

	// At most one access to the word store per transaction
	typedef struct packed {
		logic  we;
		logic  re;
		idx_t  addr;
		word_t wdata;
	} mem_req_t;

	function automatic idx_t ring_next(input idx_t i);
		return (i == idx_t'(DEPTH - 1)) ? '0 : i + idx_t'(1);
	endfunction

	function automatic idx_t ring_prev(input idx_t i);
		return (i == '0) ? idx_t'(DEPTH - 1) : i - idx_t'(1);
	endfunction

endpackage

// ----- rtl/core/double_ended_queue_top.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_top
// Double-ended queue of signed 32-bit words in a circular RAM buffer.
// ----------------------------------------------------------------------------
// Usage:
//   Drive opcode and push_value with start high; the transaction is taken
//   at a clock edge where start is high and busy is low. busy stays low, so
//   a new transaction may be issued every cycle.
//   Opcodes: push rear, push front, pop front, pop rear.
//   Each transaction yields exactly one result in the following cycle: done pulses
//   for one cycle with pop_value, status and occupancy valid in that cycle.
//   Throughput is 1 transaction per cycle; the single RAM port serves at most
//   one read or write per transaction, with a registered read.
//   A push to a full queue changes nothing and reports full; a pop from an
//   empty queue returns -1 and reports empty.
//   The receiver cannot stall; results must be captured when done is high.
//   Reset (arst_n low) empties the queue and clears both ring pointers; the
//   RAM contents are not cleared and are never read before being written.
// ----------------------------------------------------------------------------
module double_ended_queue_top (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               start,
	output logic               busy,
	input  logic [1:0]         opcode,
	input  logic signed [31:0] push_value,
	output logic               done,
	output logic signed [31:0] pop_value,
	output logic [1:0]         status,
	output logic [4:0]         occupancy
);

	dq_pkg::mem_req_t mem_req;
	dq_pkg::word_t    rdata;
	logic             accept;

	assign busy   = 1'b0;
	assign accept = start && !busy;

	dq_ctrl u_ctrl (
		.clk        (clk),
		.arst_n     (arst_n),
		.accept     (accept),
		.opcode     (opcode),
		.push_value (push_value),
		.rdata      (rdata),
		.mem_req    (mem_req),
		.done       (done),
		.pop_value  (pop_value),
		.status     (status),
		.occupancy  (occupancy)
	);

	dq_ram #(
		.WIDTH (dq_pkg::WORD_W),
		.DEPTH (dq_pkg::DEPTH)
	) u_ram (
		.clk   (clk),
		.we    (mem_req.we),
		.re    (mem_req.re),
		.addr  (mem_req.addr),
		.wdata (mem_req.wdata),
		.rdata (rdata)
	);

	a_one_result: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> done)
		else $error("transaction without result");

	a_no_spurious: assert property (@(posedge clk) disable iff (!arst_n)
		!accept |=> !done)
		else $error("result without transaction");

	a_empty_pop: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == dq_pkg::ST_EMPTY) |-> (pop_value == -32'sd1 && occupancy == '0))
		else $error("empty pop reported wrong value or occupancy");

	a_full_push: assert property (@(posedge clk) disable iff (!arst_n)
		(done && status == dq_pkg::ST_FULL)
			|-> (occupancy == dq_pkg::OCC_W'(dq_pkg::DEPTH) && pop_value == '0))
		else $error("full push reported wrong occupancy");

	a_no_write_on_read: assert property (@(posedge clk) disable iff (!arst_n)
		!(mem_req.we && mem_req.re))
		else $error("read and write issued together");

endmodule

// ----- rtl/core/dq_ram.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_ram
// Generic single-port synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module dq_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] addr,
	input  logic [WIDTH-1:0]         wdata,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[addr] <= wdata;
		end
		if (re) begin
			rdata <= mem[addr];
		end
	end

endmodule

// ----- rtl/core/dq_ctrl.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// dq_ctrl
// Ring pointers, occupancy count and the result stage of the deque.
// ----------------------------------------------------------------------------
module dq_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              accept,
	input  logic [1:0]        opcode,
	input  logic signed [31:0] push_value,
	input  dq_pkg::word_t     rdata,
	output dq_pkg::mem_req_t  mem_req,
	output logic              done,
	output logic signed [31:0] pop_value,
	output logic [1:0]        status,
	output logic [4:0]        occupancy
);

	dq_pkg::idx_t    front_q, rear_q, front_d, rear_d;
	dq_pkg::cnt_t    count_q, count_d;
	dq_pkg::status_t status_d;
	dq_pkg::op_t     op;
	logic            full, empty;

	logic            done_s1;
	logic            pop_ok_s1;
	dq_pkg::status_t status_s1;
	dq_pkg::cnt_t    count_s1;

	assign op    = dq_pkg::op_t'(opcode);
	assign full  = (count_q == dq_pkg::cnt_t'(dq_pkg::DEPTH));
	assign empty = (count_q == '0);

	always_comb begin
		front_d       = front_q;
		rear_d        = rear_q;
		count_d       = count_q;
		status_d      = dq_pkg::ST_DONE;
		mem_req.we    = 1'b0;
		mem_req.re    = 1'b0;
		mem_req.addr  = rear_q;
		mem_req.wdata = push_value;
		unique case (op)
			dq_pkg::OP_PUSH_REAR: begin
				if (full) begin
					status_d = dq_pkg::ST_FULL;
				end else begin
					mem_req.we   = accept;
					mem_req.addr = rear_q;
					rear_d       = dq_pkg::ring_next(rear_q);
					count_d      = count_q + dq_pkg::cnt_t'(1);
				end
			end
			dq_pkg::OP_PUSH_FRONT: begin
				if (full) begin
					status_d = dq_pkg::ST_FULL;
				end else begin
					mem_req.we   = accept;
					mem_req.addr = dq_pkg::ring_prev(front_q);
					front_d      = dq_pkg::ring_prev(front_q);
					count_d      = count_q + dq_pkg::cnt_t'(1);
				end
			end
			dq_pkg::OP_POP_FRONT: begin
				if (empty) begin
					status_d = dq_pkg::ST_EMPTY;
				end else begin
					mem_req.re   = accept;
					mem_req.addr = front_q;
					front_d      = dq_pkg::ring_next(front_q);
					count_d      = count_q - dq_pkg::cnt_t'(1);
				end
			end
			dq_pkg::OP_POP_REAR: begin
				if (empty) begin
					status_d = dq_pkg::ST_EMPTY;
				end else begin
					mem_req.re   = accept;
					mem_req.addr = dq_pkg::ring_prev(rear_q);
					rear_d       = dq_pkg::ring_prev(rear_q);
					count_d      = count_q - dq_pkg::cnt_t'(1);
				end
			end
			default: begin
			end
		endcase
		// last word popped: both ends go home
		if (!empty && count_d == '0) begin
			front_d = '0;
			rear_d  = '0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			front_q <= '0;
			rear_q  <= '0;
			count_q <= '0;
			done_s1 <= 1'b0;
		end else begin
			done_s1 <= accept;
			if (accept) begin
				front_q <= front_d;
				rear_q  <= rear_d;
				count_q <= count_d;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			pop_ok_s1 <= mem_req.re;
			status_s1 <= status_d;
			count_s1  <= count_d;
		end
	end

	// read data lands in the cycle after the access, together with the strobe
	always_comb begin
		if (pop_ok_s1) begin
			pop_value = rdata;
		end else if (status_s1 == dq_pkg::ST_EMPTY) begin
			pop_value = '1;
		end else begin
			pop_value = '0;
		end
	end

	assign done      = done_s1;
	assign status    = status_s1;
	assign occupancy = dq_pkg::OCC_W'(count_s1);

endmodule

// ----- tb/double_ended_queue_top_tb.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// double_ended_queue_top_tb
// Self-checking bench for the double-ended queue. A driver issues queued
// push/pop transactions and a local deque predictor computes each expected
// result at acceptance. The monitor compares every done pulse, field by
// field, against the oldest pending prediction.
// ----------------------------------------------------------------------------
module double_ended_queue_top_tb;

	localparam int RANDOM_OPS   = 600;
	localparam int CYCLE_LIMIT  = 200000;
	localparam int DRAIN_CYCLES = 8;

	typedef struct {
		dq_pkg::op_t   op;
		dq_pkg::word_t value;
	} deque_cmd_t;

	typedef struct {
		dq_pkg::word_t            pop_value;
		dq_pkg::status_t          status;
		logic [dq_pkg::OCC_W-1:0] occupancy;
	} deque_result_t;

	typedef enum {BURST_FILL, BURST_DRAIN, BURST_MIX} burst_t;

	logic               clk;
	logic               arst_n;
	logic               start;
	logic               busy;
	logic [1:0]         opcode;
	logic signed [31:0] push_value;
	logic               done;
	logic signed [31:0] pop_value;
	logic [1:0]         status;
	logic [4:0]         occupancy;

	double_ended_queue_top dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.start      (start),
		.busy       (busy),
		.opcode     (opcode),
		.push_value (push_value),
		.done       (done),
		.pop_value  (pop_value),
		.status     (status),
		.occupancy  (occupancy)
	);

	deque_cmd_t    cmd_fifo[$];
	deque_result_t result_fifo[$];

	// Predictor state
	dq_pkg::word_t model_ring [dq_pkg::DEPTH];
	dq_pkg::idx_t  model_front;
	dq_pkg::idx_t  model_rear;
	int unsigned   model_count;

	int          issued;
	int          cmd_total;
	int          errors;
	int unsigned cycles;

	always #2 clk = ~clk;

	function automatic deque_result_t deque_predict(input dq_pkg::op_t op,
		input dq_pkg::word_t value);
		deque_result_t r;
		r.pop_value = '0;
		r.status    = dq_pkg::ST_DONE;
		case (op)
			dq_pkg::OP_PUSH_REAR, dq_pkg::OP_PUSH_FRONT: begin
				if (model_count >= dq_pkg::DEPTH) begin
					r.status = dq_pkg::ST_FULL;
				end else begin
					if (op == dq_pkg::OP_PUSH_REAR) begin
						model_ring[model_rear] = value;
						model_rear = (model_rear == dq_pkg::idx_t'(dq_pkg::DEPTH - 1))
							? '0 : model_rear + 1'b1;
					end else begin
						model_front = (model_front == '0)
							? dq_pkg::idx_t'(dq_pkg::DEPTH - 1) : model_front - 1'b1;
						model_ring[model_front] = value;
					end
					model_count++;
				end
			end
			default: begin
				if (model_count == 0) begin
					r.pop_value = '1;
					r.status    = dq_pkg::ST_EMPTY;
				end else begin
					if (op == dq_pkg::OP_POP_FRONT) begin
						r.pop_value = model_ring[model_front];
						model_front = (model_front == dq_pkg::idx_t'(dq_pkg::DEPTH - 1))
							? '0 : model_front + 1'b1;
					end else begin
						model_rear = (model_rear == '0)
							? dq_pkg::idx_t'(dq_pkg::DEPTH - 1) : model_rear - 1'b1;
						r.pop_value = model_ring[model_rear];
					end
					model_count--;
					// draining the last word re-centers both pointers
					if (model_count == 0) begin
						model_front = '0;
						model_rear  = '0;
					end
				end
			end
		endcase
		r.occupancy = model_count[dq_pkg::OCC_W-1:0];
		return r;
	endfunction

	function automatic dq_pkg::word_t random_word();
		case ($urandom_range(9))
			0: return 32'h8000_0000;
			1: return 32'h7FFF_FFFF;
			2: return '0;
			3: return '1;
			default: return $urandom;
		endcase
	endfunction

	task automatic add_cmd(input dq_pkg::op_t op, input dq_pkg::word_t value);
		deque_cmd_t c;
		c.op    = op;
		c.value = value;
		cmd_fifo.push_back(c);
	endtask

	// Driver: records the accepted transaction, then presents the next one
	always @(posedge clk) begin
		deque_cmd_t nxt;
		int         idle_pct;
		if (arst_n) begin
			if (start && !busy) begin
				result_fifo.push_back(deque_predict(dq_pkg::op_t'(opcode), push_value));
				issued++;
			end
			if (issued < cmd_total / 3)
				idle_pct = 19;
			else if (issued < (2 * cmd_total) / 3)
				idle_pct = 72;
			else
				idle_pct = 0;
			if (!(start && busy)) begin
				if (cmd_fifo.size() != 0 && $urandom_range(99) >= idle_pct) begin
					nxt = cmd_fifo.pop_front();
					start      <= 1'b1;
					opcode     <= nxt.op;
					push_value <= nxt.value;
				end else begin
					start <= 1'b0;
				end
			end
		end
	end

	// Monitor
	always @(posedge clk) begin
		deque_result_t want;
		if (arst_n && done) begin
			if (result_fifo.size() == 0) begin
				$error("unexpected result: pop_value %0d status %0d occupancy %0d",
					pop_value, status, occupancy);
				errors++;
			end else begin
				want = result_fifo.pop_front();
				if (pop_value !== want.pop_value) begin
					$error("pop_value: expected %0d, actual %0d",
						$signed(want.pop_value), pop_value);
					errors++;
				end
				if (status !== want.status) begin
					$error("status: expected %0d, actual %0d", want.status, status);
					errors++;
				end
				if (occupancy !== want.occupancy) begin
					$error("occupancy: expected %0d, actual %0d", want.occupancy, occupancy);
					errors++;
				end
			end
		end
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles >= CYCLE_LIMIT) begin
			$display("Verification failed");
			$finish;
		end
	end

	initial begin
		burst_t      mode;
		int          burst_len;
		int          n;
		int          k;
		int          roll;
		dq_pkg::op_t op;

		clk         = 1'b0;
		arst_n      = 1'b0;
		start       = 1'b0;
		opcode      = '0;
		push_value  = '0;
		cycles      = 0;
		errors      = 0;
		issued      = 0;
		cmd_total   = 0;
		model_front = '0;
		model_rear  = '0;
		model_count = 0;

		// Directed: empty pops, extreme words, emptying pop, front wrap, full pushes
		add_cmd(dq_pkg::OP_POP_FRONT, 32'h1234_5678);
		add_cmd(dq_pkg::OP_POP_REAR, 32'hFFFF_FFFF);
		add_cmd(dq_pkg::OP_PUSH_REAR, 32'h8000_0000);
		add_cmd(dq_pkg::OP_PUSH_FRONT, 32'h7FFF_FFFF);
		add_cmd(dq_pkg::OP_POP_REAR, '0);
		add_cmd(dq_pkg::OP_POP_FRONT, '0);
		for (k = 0; k < dq_pkg::DEPTH; k++)
			add_cmd((k % 2) ? dq_pkg::OP_PUSH_REAR : dq_pkg::OP_PUSH_FRONT, random_word());
		add_cmd(dq_pkg::OP_PUSH_REAR, 32'hFFFF_FFFF);
		add_cmd(dq_pkg::OP_PUSH_FRONT, 32'h0000_0001);

		// Random bursts: filling and draining runs walk the ring through full and empty
		n = 0;
		while (n < RANDOM_OPS) begin
			mode      = burst_t'($urandom_range(2));
			burst_len = $urandom_range(40, 6);
			for (k = 0; k < burst_len; k++) begin
				roll = $urandom_range(99);
				case (mode)
					BURST_FILL:
						op = (roll < 85) ? dq_pkg::op_t'($urandom_range(1, 0))
						                 : dq_pkg::op_t'($urandom_range(3, 2));
					BURST_DRAIN:
						op = (roll < 85) ? dq_pkg::op_t'($urandom_range(3, 2))
						                 : dq_pkg::op_t'($urandom_range(1, 0));
					default:
						op = dq_pkg::op_t'($urandom_range(3));
				endcase
				add_cmd(op, random_word());
				n++;
			end
		end
		cmd_total = cmd_fifo.size();

		repeat (2) @(posedge clk);
		arst_n <= 1'b1;

		while (cmd_fifo.size() != 0 || start)
			@(posedge clk);
		while (result_fifo.size() != 0)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);

		if (errors == 0 && result_fifo.size() == 0) begin
			$display("Verification passed");
		end else begin
			$display("Verification failed");
		end
		$finish;
	end

endmodule
